>>> rtl/wshb_pkg.sv
// ----------------------------------------------------------------------------
// Sample history buffer package
// Shared item types, field widths and the command and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package wshb_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int COUNT_W   = 7;
  localparam int INDEX_W   = 64;
  localparam int CFG_W     = 11;
  localparam int CAP_RESET = 1024;

  // Operation carried by an input item.
  typedef enum logic [1:0] {
    MODE_WRITE   = 2'd0,
    MODE_LATEST  = 2'd1,
    MODE_EXACT   = 2'd2,
    MODE_CLIPPED = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e                mode;
    logic [SAMPLE_W-1:0]  sample_in;
    logic [COUNT_W-1:0]   request_count;
    logic [INDEX_W-1:0]   window_end;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0]  sample_out;
    logic                 sample_valid;
    logic [COUNT_W-1:0]   returned_count;
    logic [INDEX_W-1:0]   total_written;
    logic                 last;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic take_item;
    logic calc_avail;
    logic calc_oldest;
    logic decide;
    logic calc_back;
    logic calc_slot;
    logic emit_empty;
    logic stream;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic item_is_write;
    logic reply_ok;
    logic issue_done;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/wshb_ctrl.sv
// ----------------------------------------------------------------------------
// Sample history buffer controller
// Sequences a read through the window arithmetic steps and then either the
// sample stream or the empty reply. Writes finish in the accept cycle.
// ----------------------------------------------------------------------------
module wshb_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  wshb_pkg::sts_t  sts_i,
  output wshb_pkg::cmd_t  cmd_o
);
  import wshb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVAIL,
    ST_OLDEST,
    ST_DECIDE,
    ST_BACK,
    ST_SLOT,
    ST_EMPTY,
    ST_STREAM
  } state_e;

  state_e state_q;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Commands are decoded from the current state.
  always_comb begin
    cmd_o             = '0;
    cmd_o.take_item   = accept;
    cmd_o.calc_avail  = (state_q == ST_AVAIL);
    cmd_o.calc_oldest = (state_q == ST_OLDEST);
    cmd_o.decide      = (state_q == ST_DECIDE);
    cmd_o.calc_back   = (state_q == ST_BACK);
    cmd_o.calc_slot   = (state_q == ST_SLOT);
    cmd_o.emit_empty  = (state_q == ST_EMPTY);
    cmd_o.stream      = (state_q == ST_STREAM);
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept && !sts_i.item_is_write) state_q <= ST_AVAIL;
        end
        ST_AVAIL:  state_q <= ST_OLDEST;
        ST_OLDEST: state_q <= ST_DECIDE;
        ST_DECIDE: state_q <= ST_BACK;
        ST_BACK:   state_q <= ST_SLOT;
        ST_SLOT: begin
          state_q <= sts_i.reply_ok ? ST_STREAM : ST_EMPTY;
        end
        ST_EMPTY: begin
          if (sts_i.out_free) state_q <= ST_IDLE;
        end
        ST_STREAM: begin
          if (sts_i.issue_done) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // The stream only ends once every sample has left the read stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STREAM) && !sts_i.issue_done |=> (state_q == ST_STREAM))
    else $error("stream ended before all samples were issued");

  // A read item always passes through the window arithmetic first.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !sts_i.item_is_write |=> (state_q == ST_AVAIL))
    else $error("read item did not start the window sequence");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && sts_i.item_is_write |=> (state_q == ST_IDLE))
    else $error("write item left the idle state");

endmodule

>>> rtl/wshb_dp.sv
// ----------------------------------------------------------------------------
// Sample history buffer datapath
// Sample memory, write pointer and absolute count, the window arithmetic
// registers, and a two-stage read pipeline (memory data, output register).
// ----------------------------------------------------------------------------
module wshb_dp #(
  parameter int DEPTH    = 1024,
  parameter int MAX_READ = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  wshb_pkg::cmd_t                  cmd_i,
  output wshb_pkg::sts_t                  sts_o,
  input  wshb_pkg::in_item_t              in_data_i,
  input  logic                            cfg_we_i,
  input  logic [wshb_pkg::CFG_W-1:0]      cfg_wdata_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output wshb_pkg::out_item_t             out_data_o
);
  import wshb_pkg::*;

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CAPW = $clog2(DEPTH + 1);
  localparam int PW   = CAPW + 1;
  localparam int CAP_RST = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;

  // History state.
  logic [SAMPLE_W-1:0] store_q [DEPTH];
  logic [AW-1:0]       wp_q;
  logic [INDEX_W-1:0]  total_q;
  logic [CAPW-1:0]     cap_q;

  // Latched request and window arithmetic.
  mode_e               mode_q;
  logic [COUNT_W-1:0]  n_q;
  logic [INDEX_W-1:0]  end_q;
  logic [CAPW-1:0]     avail_q;
  logic [INDEX_W-1:0]  oldest_q;
  logic [INDEX_W-1:0]  lo_q;
  logic                borrow_q;
  logic                end_gt_q;
  logic [INDEX_W-1:0]  start_q;
  logic                ok_q;
  logic [COUNT_W-1:0]  cnt_q;
  logic [CAPW-1:0]     back_q;

  // Read pipeline.
  logic [AW-1:0]       ptr_q;
  logic [COUNT_W-1:0]  remaining_q;
  logic                a_valid_q;
  logic                a_last_q;
  logic [SAMPLE_W-1:0] rdata_q;
  out_item_t           out_q;
  logic                out_valid_q;

  logic                wr_en;
  logic [CAPW-1:0]     wp_inc;
  logic [CAPW-1:0]     ptr_inc;
  logic [CAPW-1:0]     cap_new;
  logic [COUNT_W-1:0]  n_sat;
  logic [INDEX_W:0]    lo_full;
  logic [COUNT_W-1:0]  cnt_latest;
  logic [INDEX_W-1:0]  start_clip;
  logic [PW-1:0]       slot_raw;
  logic [PW-1:0]       slot;
  logic                out_free;
  logic                a_move;
  logic                issue;

  assign wr_en   = cmd_i.take_item && (in_data_i.mode == MODE_WRITE);
  assign wp_inc  = CAPW'(wp_q) + CAPW'(1);
  assign ptr_inc = CAPW'(ptr_q) + CAPW'(1);

  // Effective capacity clamped to 1..DEPTH.
  always_comb begin
    if (cfg_wdata_i == '0) begin
      cap_new = CAPW'(1);
    end else if (32'(cfg_wdata_i) > DEPTH) begin
      cap_new = CAPW'(DEPTH);
    end else begin
      cap_new = CAPW'(cfg_wdata_i);
    end
  end

  // Request count saturates at the largest read.
  assign n_sat = (in_data_i.request_count > COUNT_W'(MAX_READ)) ?
                 COUNT_W'(MAX_READ) : in_data_i.request_count;

  assign lo_full    = {1'b0, end_q} - (INDEX_W + 1)'(n_q);
  assign cnt_latest = (32'(n_q) < 32'(avail_q)) ? n_q : COUNT_W'(avail_q);

  // Clipped window start: end minus N floored at zero, then at the oldest index.
  always_comb begin
    start_clip = borrow_q ? '0 : lo_q;
    if (start_clip < oldest_q) start_clip = oldest_q;
  end

  // Ring slot of the first sample, counted back from the write pointer.
  always_comb begin
    if (PW'(wp_q) >= PW'(back_q)) begin
      slot_raw = PW'(wp_q) - PW'(back_q);
    end else begin
      slot_raw = PW'(wp_q) + PW'(cap_q) - PW'(back_q);
    end
    slot = (slot_raw >= PW'(cap_q)) ? '0 : slot_raw;
  end

  // Pipeline handshakes.
  assign out_free = !out_valid_q || out_ready_i;
  assign a_move   = a_valid_q && out_free;
  assign issue    = cmd_i.stream && (remaining_q != '0) && (!a_valid_q || a_move);

  // Sample memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) store_q[wp_q] <= in_data_i.sample_in;
    if (issue) rdata_q <= store_q[ptr_q];
  end

  // Write pointer, absolute count and capacity.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      total_q <= '0;
      cap_q   <= CAPW'(CAP_RST);
    end else if (cfg_we_i) begin
      wp_q    <= '0;
      total_q <= '0;
      cap_q   <= cap_new;
    end else if (wr_en) begin
      wp_q    <= (wp_inc >= cap_q) ? '0 : AW'(wp_inc);
      total_q <= total_q + INDEX_W'(1);
    end
  end

  // Window arithmetic, one step per controller state.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      mode_q <= in_data_i.mode;
      n_q    <= n_sat;
      end_q  <= in_data_i.window_end;
    end
    if (cmd_i.calc_avail) begin
      avail_q  <= (total_q < INDEX_W'(cap_q)) ? total_q[CAPW-1:0] : cap_q;
      lo_q     <= lo_full[INDEX_W-1:0];
      borrow_q <= lo_full[INDEX_W];
      end_gt_q <= (end_q > total_q);
    end
    if (cmd_i.calc_oldest) begin
      oldest_q <= total_q - INDEX_W'(avail_q);
    end
    if (cmd_i.decide) begin
      case (mode_q)
        MODE_LATEST: begin
          ok_q    <= (n_q != '0) && (avail_q != '0);
          start_q <= lo_q;
        end
        MODE_EXACT: begin
          ok_q    <= (n_q != '0) && !end_gt_q && !borrow_q && (lo_q >= oldest_q);
          start_q <= lo_q;
        end
        MODE_CLIPPED: begin
          ok_q    <= (n_q != '0) && !end_gt_q && (end_q > oldest_q);
          start_q <= start_clip;
        end
        default: begin
          ok_q    <= 1'b0;
          start_q <= lo_q;
        end
      endcase
    end
    if (cmd_i.calc_back) begin
      // Both results are small, so the low bits of the differences suffice.
      case (mode_q)
        MODE_LATEST: begin
          back_q <= CAPW'(cnt_latest);
          cnt_q  <= cnt_latest;
        end
        MODE_EXACT: begin
          back_q <= total_q[CAPW-1:0] - start_q[CAPW-1:0];
          cnt_q  <= n_q;
        end
        default: begin
          back_q <= total_q[CAPW-1:0] - start_q[CAPW-1:0];
          cnt_q  <= end_q[COUNT_W-1:0] - start_q[COUNT_W-1:0];
        end
      endcase
    end
  end

  // Read pointer and remaining count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      remaining_q <= '0;
    end else if (cmd_i.calc_slot) begin
      ptr_q       <= AW'(slot);
      remaining_q <= ok_q ? cnt_q : '0;
    end else if (issue) begin
      ptr_q       <= (ptr_inc >= cap_q) ? '0 : AW'(ptr_inc);
      remaining_q <= remaining_q - COUNT_W'(1);
    end
  end

  // Memory data stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (issue) begin
      a_valid_q <= 1'b1;
    end else if (a_move) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) a_last_q <= (remaining_q == COUNT_W'(1));
  end

  // Output register: takes a sample from the data stage or the empty reply.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (a_move || (cmd_i.emit_empty && out_free)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_move) begin
      out_q.sample_out     <= rdata_q;
      out_q.sample_valid   <= 1'b1;
      out_q.returned_count <= cnt_q;
      out_q.total_written  <= total_q;
      out_q.last           <= a_last_q;
    end else if (cmd_i.emit_empty && out_free) begin
      out_q.sample_out     <= '0;
      out_q.sample_valid   <= 1'b0;
      out_q.returned_count <= '0;
      out_q.total_written  <= total_q;
      out_q.last           <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Status back to the controller.
  always_comb begin
    sts_o               = '0;
    sts_o.item_is_write = (in_data_i.mode == MODE_WRITE);
    sts_o.reply_ok      = ok_q;
    sts_o.issue_done    = (remaining_q == '0) && !a_valid_q;
    sts_o.out_free      = out_free;
  end

  // Memory reads happen only while streaming.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> cmd_i.stream)
    else $error("memory read outside the stream phase");

  // The data stage is empty whenever no stream is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.stream |-> !a_valid_q)
    else $error("data stage holds a sample outside the stream phase");

  // The write pointer stays inside the capacity in use, and the read pointer does while streaming.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    CAPW'(wp_q) < cap_q)
    else $error("write pointer beyond capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.stream |-> (CAPW'(ptr_q) < cap_q))
    else $error("read pointer beyond capacity");

endmodule

>>> rtl/windowed_sample_history_buffer_core.sv
// ----------------------------------------------------------------------------
// Windowed sample history buffer
// Ring of the newest samples with an absolute write count; serves latest,
// exact-window and clipped-window reads, oldest sample first.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one item per operation: a write stores one
//   sample, a read asks for up to MAX_READ samples. The output channel
//   carries one item per returned sample, with last set on the final one;
//   a read that finds nothing answers with a single empty item.
//   A write completes in its accept cycle; the next item is accepted in the cycle after.
//   A read steps through the window arithmetic states (avail, oldest,
//   decide, back, slot) in the controller sequence, then streams samples
//   from the single memory read port at one per cycle while the receiver
//   takes them, each through the memory data and output registers; an
//   empty reply goes straight to the output register. The output register
//   lets the next item be accepted while the final result still waits.
//   A stalled receiver stalls the read stream, and through it the input
//   channel. Reset clears the write pointer, the count and the capacity
//   (to 1024, or DEPTH if smaller); the sample memory is not cleared. A
//   capacity write clears the history in the same way; the user must make
//   it only while idle, as the block does not enforce this.
// ----------------------------------------------------------------------------
module windowed_sample_history_buffer_core #(
  parameter int DEPTH    = 1024,
  parameter int MAX_READ = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  wshb_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output wshb_pkg::out_item_t           out_data_o,
  input  logic                          cfg_we_i,
  input  logic [wshb_pkg::CFG_W-1:0]    cfg_wdata_i
);
  import wshb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencing.
  wshb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Storage, window arithmetic and read pipeline.
  wshb_dp #(
    .DEPTH    (DEPTH),
    .MAX_READ (MAX_READ)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> sim/tb_windowed_sample_history_buffer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the windowed sample history buffer
// A table of directed items covers the empty replies, the field extremes and
// the overwrite cases. Random items follow over several capacity settings.
// Every result item is checked against a typed reply or the ring predictor.
// ----------------------------------------------------------------------------
module tb_windowed_sample_history_buffer_core;
  import wshb_pkg::*;

  localparam int          DEPTH_C     = 1024;
  localparam int          MAX_READ_C  = 64;
  localparam int          PHASE_ITEMS = 54;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  // One row of the directed table: a capacity write or an input item, with
  // the reply typed in where it is obvious.
  typedef struct packed {
    bit                 is_cfg;
    logic [CFG_W-1:0]   cfg_val;
    in_item_t           item;
    bit                 typed;
    out_item_t          result;
  } dir_row_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  in_item_t         in_data_i   = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  out_item_t        out_data_o;
  logic             cfg_we_i    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  // Predicted state of the ring.
  logic [SAMPLE_W-1:0] hist_store [DEPTH_C];
  int unsigned         hist_wpos;
  logic [INDEX_W-1:0]  hist_total;
  logic [CFG_W-1:0]    hist_cap_reg;

  out_item_t   awaited_replies [$];
  out_item_t   want_item;
  int unsigned fail_count   = 0;
  int unsigned cycle_count  = 0;
  int unsigned send_idle_pct = 11;
  int unsigned recv_idle_pct = 80;
  bit          hold_pending  = 1'b0;

  always #2 clk_i = ~clk_i;

  windowed_sample_history_buffer_core #(
    .DEPTH   (DEPTH_C),
    .MAX_READ(MAX_READ_C)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Capacity in effect: the register clamped to 1..DEPTH.
  function automatic int unsigned eff_cap();
    if (hist_cap_reg == '0) return 1;
    if (hist_cap_reg > DEPTH_C) return DEPTH_C;
    return int'(hist_cap_reg);
  endfunction

  function automatic out_item_t empty_reply(input logic [INDEX_W-1:0] total);
    out_item_t r;
    r = '0;
    r.total_written = total;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic in_item_t mk_item(input mode_e m, input logic [SAMPLE_W-1:0] s,
                                       input logic [COUNT_W-1:0] n,
                                       input logic [INDEX_W-1:0] e);
    in_item_t it;
    it.mode = m;
    it.sample_in = s;
    it.request_count = n;
    it.window_end = e;
    return it;
  endfunction

  function automatic dir_row_t item_row(input in_item_t it);
    return '{1'b0, '0, it, 1'b0, '0};
  endfunction

  function automatic dir_row_t typed_row(input in_item_t it, input out_item_t r);
    return '{1'b0, '0, it, 1'b1, r};
  endfunction

  // Queue the samples of the window that starts at absolute index first.
  task automatic queue_window(input logic [INDEX_W-1:0] first, input logic [INDEX_W-1:0] cnt);
    out_item_t   r;
    int unsigned cap, slot, back;
    cap = eff_cap();
    if (cnt == 0) begin
      awaited_replies.push_back(empty_reply(hist_total));
      return;
    end
    back = 32'(hist_total - first);
    slot = (hist_wpos >= back) ? hist_wpos - back : hist_wpos + cap - back;
    if (slot >= cap) slot = 0;
    for (int k = 0; k < int'(cnt); k++) begin
      r.sample_out = hist_store[slot];
      r.sample_valid = 1'b1;
      r.returned_count = cnt[COUNT_W-1:0];
      r.total_written = hist_total;
      r.last = (k + 1 == int'(cnt));
      awaited_replies.push_back(r);
      slot++;
      if (slot >= cap) slot = 0;
    end
  endtask

  // Apply one accepted item to the predicted ring and queue its replies.
  task automatic history_step(input in_item_t it);
    int unsigned        cap;
    logic [INDEX_W-1:0] n, avail, oldest, first, last_end;
    cap = eff_cap();
    n = 64'(it.request_count);
    if (n > 64'(MAX_READ_C)) n = 64'(MAX_READ_C);
    last_end = it.window_end;
    if (it.mode == MODE_WRITE) begin
      if (hist_wpos >= cap) hist_wpos = 0;
      hist_store[hist_wpos] = it.sample_in;
      hist_wpos++;
      if (hist_wpos >= cap) hist_wpos = 0;
      hist_total++;
      return;
    end
    avail = (hist_total < 64'(cap)) ? hist_total : 64'(cap);
    oldest = hist_total - avail;
    case (it.mode)
      MODE_LATEST: begin
        first = (n < avail) ? n : avail;
        queue_window(hist_total - first, first);
      end
      MODE_EXACT: begin
        if (n == 0 || last_end > hist_total || last_end < n || last_end - n < oldest)
          queue_window('0, '0);
        else
          queue_window(last_end - n, n);
      end
      default: begin
        if (n == 0 || last_end > hist_total || last_end <= oldest) begin
          queue_window('0, '0);
        end else begin
          first = (last_end > n) ? last_end - n : '0;
          if (first < oldest) first = oldest;
          queue_window(first, last_end - first);
        end
      end
    endcase
  endtask

  // Random item: mostly windows near the newest samples, some far off.
  function automatic in_item_t rand_item();
    in_item_t    it;
    int unsigned pick, avail, span;
    logic [INDEX_W-1:0] oldest;
    avail = (hist_total < 64'(eff_cap())) ? 32'(hist_total) : eff_cap();
    oldest = hist_total - 64'(avail);
    pick = $urandom_range(99);
    if (pick < 45)      it.mode = MODE_WRITE;
    else if (pick < 63) it.mode = MODE_LATEST;
    else if (pick < 82) it.mode = MODE_EXACT;
    else                it.mode = MODE_CLIPPED;
    it.sample_in = $urandom;
    pick = $urandom_range(99);
    if (pick < 5)       it.request_count = '0;
    else if (pick < 75) it.request_count = 7'($urandom_range(1, 16));
    else if (pick < 90) it.request_count = 7'($urandom_range(17, 64));
    else                it.request_count = 7'($urandom_range(65, 127));
    pick = $urandom_range(99);
    if (pick < 10) begin
      it.window_end = {$urandom, $urandom};
    end else if (pick < 18) begin
      it.window_end = hist_total + 64'($urandom_range(1, 3));
    end else if (pick < 30) begin
      it.window_end = 64'($urandom_range(0, 32'(hist_total)));
    end else begin
      it.window_end = hist_total - 64'($urandom_range(0, avail));
      // A well-formed exact window that lies fully inside the held samples.
      if (it.mode == MODE_EXACT && it.window_end > oldest && $urandom_range(1) == 1) begin
        span = 32'(it.window_end - oldest);
        it.request_count = 7'($urandom_range(1, (span < MAX_READ_C) ? span : MAX_READ_C));
      end
    end
    return it;
  endfunction

  // Offer one item from a falling edge and return at the falling edge after
  // it has been taken.
  task automatic drive_item(input in_item_t it, input bit typed, input out_item_t result);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (typed) awaited_replies.push_back(result);
    else history_step(it);
    @(negedge clk_i);
  endtask

  // Wait until all replies are in, then let the block settle.
  task automatic wait_idle(input int tail);
    in_valid_i <= 1'b0;
    while (awaited_replies.size() != 0) @(negedge clk_i);
    repeat (tail) @(negedge clk_i);
  endtask

  task automatic set_capacity(input logic [CFG_W-1:0] value);
    wait_idle(12);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    hist_cap_reg = value;
    hist_wpos = 0;
    hist_total = '0;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      fail_count++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compare each taken result item with the oldest awaited reply.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_replies.size() == 0) begin
        fail_count++;
        $error("result item with no reply awaited: %0h", out_data_o);
      end else begin
        want_item = awaited_replies.pop_front();
        check_field("sample_out", want_item.sample_out, out_data_o.sample_out);
        check_field("sample_valid", want_item.sample_valid, out_data_o.sample_valid);
        check_field("returned_count", want_item.returned_count, out_data_o.returned_count);
        check_field("total_written", want_item.total_written, out_data_o.total_written);
        check_field("last", want_item.last, out_data_o.last);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("timeout with %0d replies still awaited", awaited_replies.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t         dir_rows [$];
    logic [CFG_W-1:0] phase_caps [8];

    hist_wpos = 0;
    hist_total = '0;
    hist_cap_reg = CFG_W'(CAP_RESET);
    phase_caps = '{11'd3, 11'd0, 11'd64, 11'd2047, 11'd1, 11'd200, 11'd1025, 11'd5};

    // Reads before any write, then four extreme samples and every window rule.
    dir_rows.push_back(typed_row(mk_item(MODE_LATEST, '0, 7'd5, '0), empty_reply(64'd0)));
    dir_rows.push_back(typed_row(mk_item(MODE_EXACT, '0, 7'd1, '0), empty_reply(64'd0)));
    dir_rows.push_back(typed_row(mk_item(MODE_CLIPPED, '0, 7'd1, '0), empty_reply(64'd0)));
    dir_rows.push_back(item_row(mk_item(MODE_WRITE, 32'h0000_0000, '0, '0)));
    dir_rows.push_back(item_row(mk_item(MODE_WRITE, 32'hFFFF_FFFF, 7'd127, '1)));
    dir_rows.push_back(item_row(mk_item(MODE_WRITE, 32'h7FC0_0000, '0, '0)));
    dir_rows.push_back(item_row(mk_item(MODE_WRITE, 32'h8000_0000, '0, '0)));
    dir_rows.push_back(typed_row(mk_item(MODE_LATEST, '0, 7'd1, '0),
                                 '{32'h8000_0000, 1'b1, 7'd1, 64'd4, 1'b1}));
    dir_rows.push_back(typed_row(mk_item(MODE_LATEST, '0, 7'd0, '0), empty_reply(64'd4)));
    // Request above the maximum is cut to the maximum, then to what is held.
    dir_rows.push_back(item_row(mk_item(MODE_LATEST, '0, 7'd127, '0)));
    dir_rows.push_back(item_row(mk_item(MODE_EXACT, '0, 7'd4, 64'd4)));
    dir_rows.push_back(typed_row(mk_item(MODE_EXACT, '0, 7'd1, 64'd5), empty_reply(64'd4)));
    dir_rows.push_back(typed_row(mk_item(MODE_EXACT, '0, 7'd64, '1), empty_reply(64'd4)));
    dir_rows.push_back(typed_row(mk_item(MODE_EXACT, '0, 7'd5, 64'd4), empty_reply(64'd4)));
    dir_rows.push_back(item_row(mk_item(MODE_CLIPPED, '0, 7'd10, 64'd3)));
    dir_rows.push_back(typed_row(mk_item(MODE_CLIPPED, '0, 7'd0, 64'd2), empty_reply(64'd4)));
    dir_rows.push_back(item_row(mk_item(MODE_CLIPPED, '0, 7'd64, 64'd4)));
    // A capacity of two clears the history and overwrites after two writes.
    dir_rows.push_back('{1'b1, 11'd2, '0, 1'b0, '0});
    dir_rows.push_back(typed_row(mk_item(MODE_LATEST, '0, 7'd64, '0), empty_reply(64'd0)));
    dir_rows.push_back(item_row(mk_item(MODE_WRITE, 32'h1234_5678, '0, '0)));
    dir_rows.push_back(item_row(mk_item(MODE_WRITE, 32'h89AB_CDEF, '0, '0)));
    dir_rows.push_back(item_row(mk_item(MODE_WRITE, 32'h5555_AAAA, '0, '0)));
    dir_rows.push_back(item_row(mk_item(MODE_EXACT, '0, 7'd2, 64'd3)));
    dir_rows.push_back(typed_row(mk_item(MODE_EXACT, '0, 7'd3, 64'd3), empty_reply(64'd3)));
    dir_rows.push_back(typed_row(mk_item(MODE_CLIPPED, '0, 7'd1, 64'd1), empty_reply(64'd3)));
    dir_rows.push_back(item_row(mk_item(MODE_CLIPPED, '0, 7'd3, 64'd3)));
    dir_rows.push_back(item_row(mk_item(MODE_LATEST, '0, 7'd64, '0)));

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) set_capacity(dir_rows[i].cfg_val);
      else drive_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].result);
    end

    // Random phases over several capacities, including both clamped ends.
    for (int p = 0; p < 8; p++) begin
      if (p == 3) begin
        send_idle_pct = 80;
        recv_idle_pct = 11;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_capacity((p == 7) ? CFG_W'($urandom_range(1, 2047)) : phase_caps[p]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Long receiver hold-off so the block backs up into its input.
        if (p == 2 && k == 10) hold_pending = 1'b1;
        drive_item(rand_item(), 1'b0, '0);
      end
    end

    wait_idle(20);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
